@@ hw/rtl/gdm_pkg.sv @@
`default_nettype none

package gdm_pkg;

   // Default table sizes.
   localparam int NUM_REACTIONS_DEF = 16;
   localparam int NUM_SPECIES_DEF = 8;

   // Reaction code reported when nothing fired.
   localparam logic [4:0] NO_REACTION = 5'd16;

   // ln(2) as a 0.32 fraction.
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   // Reciprocal of three for 32-bit division by three (shift by 33).
   localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

   localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

   // Operation codes carried in tuser of the request word.
   typedef enum logic [2:0] {
      OP_WRITE_REACTION = 3'd0,
      OP_WRITE_COUNT    = 3'd1,
      OP_SIMULATE       = 3'd2,
      OP_CLEAR          = 3'd3,
      OP_READ_COUNT     = 3'd4
   } op_type;

   // Status codes carried in tuser of the response word.
   typedef enum logic [1:0] {
      ST_DONE   = 2'd0,
      ST_FIRED  = 2'd1,
      ST_HALTED = 2'd2
   } status_type;

endpackage

`default_nettype wire

@@ hw/rtl/gillespie_direct_method_step.sv @@
// Writes, reads and clears are answered from the idle state and may follow each other
// every cycle while the response side takes each answer. A simulate word computes each
// reaction's propensity with 64-bit saturating multiplies (up to three per species plus
// the rate), then normalizes, takes the log, divides, walks the reactions to select and
// updates one species a cycle; the single shared 32x32 multiplier does every multiply.
// Reset is synchronous and clears tables, counts, time and the halt flag.
`default_nettype none

module gillespie_direct_method_step #(
   parameter int NUM_REACTIONS = gdm_pkg::NUM_REACTIONS_DEF,
   parameter int NUM_SPECIES = gdm_pkg::NUM_SPECIES_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // index[3:0], rate[35:4], reactant_orders[51:36], changes[83:52],
   // stochastic[84], count_value[116:85], rand_time[148:117], rand_pick[180:149]
   input  wire logic [183:0] req_tdata,
   // operation[2:0]
   input  wire logic [2:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // reaction[4:0], sim_time_out[68:5], time_step[132:69],
   // total_propensity[196:133], count_out[228:197]
   output logic [231:0]      rsp_tdata,
   // status[1:0]
   output logic [1:0]        rsp_tuser
);

   localparam int RW = (NUM_REACTIONS > 1) ? $clog2(NUM_REACTIONS) : 1;
   localparam int SW = (NUM_SPECIES > 1) ? $clog2(NUM_SPECIES) : 1;
   localparam int SL = (NUM_SPECIES < 8) ? NUM_SPECIES : 8;

   typedef enum logic [4:0] {
      S_IDLE, S_P_START, S_P_SPEC, S_P_B2, S_P_D3, S_P_B3A, S_P_B3B, S_P_HMUL,
      S_P_HDONE, S_P_RATE, S_P_STORE, S_HALT_CHK, S_LN_NORM, S_LN_SQ, S_LN_SQU,
      S_LN_FIN, S_LN_M0, S_LN_M1, S_LN_M2, S_DIV_INIT, S_DIV, S_TG0, S_TG1,
      S_TG2, S_SEL_ADDR, S_SEL_DATA, S_APPLY, S_SM0, S_SM1, S_SM2
   } state_type;

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? gdm_pkg::U64_MAX : s[63:0];
   endfunction

   // Request fields.
   logic [2:0]  req_op;
   logic [3:0]  req_index;
   logic [31:0] req_rate;
   logic [15:0] req_orders;
   logic [31:0] req_changes;
   logic        req_stoch;
   logic [31:0] req_count;
   logic [31:0] req_rtime;
   logic [31:0] req_rpick;

   assign req_op      = req_tuser;
   assign req_index   = req_tdata[3:0];
   assign req_rate    = req_tdata[35:4];
   assign req_orders  = req_tdata[51:36];
   assign req_changes = req_tdata[83:52];
   assign req_stoch   = req_tdata[84];
   assign req_count   = req_tdata[116:85];
   assign req_rtime   = req_tdata[148:117];
   assign req_rpick   = req_tdata[180:149];

   // Registers.
   state_type state_ff, state_in, ret_ff, ret_in;
   logic [31:0] rate_ff [NUM_REACTIONS], rate_in [NUM_REACTIONS];
   logic [15:0] order_ff [NUM_REACTIONS], order_in [NUM_REACTIONS];
   logic [31:0] change_ff [NUM_REACTIONS], change_in [NUM_REACTIONS];
   logic        flag_ff [NUM_REACTIONS], flag_in [NUM_REACTIONS];
   logic [31:0] count_ff [NUM_SPECIES], count_in [NUM_SPECIES];
   logic [63:0] sim_time_ff, sim_time_in;
   logic        halted_ff, halted_in;
   logic [RW-1:0] r_ff, r_in, pick_ff, pick_in;
   logic [3:0]  s_ff, s_in;
   logic [63:0] h_ff, h_in, bin_ff, bin_in, sa_ff, sa_in, sb_ff, sb_in;
   logic [63:0] sres_ff, sres_in;
   logic [31:0] p0_ff, p0_in;
   logic [63:0] p0w_ff, p0w_in;
   logic [31:0] n_ff, n_in, f2_ff, f2_in;
   logic [63:0] a0_ff, a0_in, sum_ff, sum_in, target_ff, target_in;
   logic [63:0] l_ff, l_in, dq_ff, dq_in, rem_ff, rem_in;
   logic [31:0] m_ff, m_in, frac_ff, frac_in, rt_ff, rt_in, rp_ff, rp_in;
   logic [4:0]  e_ff, e_in;
   logic [5:0]  it_ff, it_in;
   logic [63:0] mul_p_ff;
   logic [31:0] mul_a, mul_b;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  status_ff, status_in;
   logic [4:0]  react_ff, react_in;
   logic [63:0] time_out_ff, time_out_in, dt_out_ff, dt_out_in, a0_out_ff, a0_out_in;
   logic [31:0] cnt_out_ff, cnt_out_in;

   // Working values.
   logic        accept;
   logic [SW-1:0] cnt_addr;
   logic [31:0] cnt_rd;
   logic [1:0]  ord;
   logic [95:0] sm_tot;
   logic        sm_ovf;
   logic [31:0] q3, three_q, rm, f0, f1, f2;
   logic [32:0] sq;
   logic [5:0]  ehi;
   logic [64:0] nrem;
   logic        ge;
   logic [63:0] nsum, upd;
   logic [3:0]  nib;
   logic [31:0] dec;
   logic [32:0] inc;
   logic        ram_we;
   logic [RW-1:0] ram_raddr;
   logic [63:0] ram_rdata;

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign cnt_addr = (state_ff == S_IDLE) ? SW'(req_index) : SW'(s_ff);
   assign cnt_rd = count_ff[cnt_addr];
   assign ram_we = (state_ff == S_P_STORE);
   assign ram_raddr = r_ff;

   gdm_ram #(
      .WIDTH(64),
      .DEPTH(NUM_REACTIONS)
   ) u_prop_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(r_ff),
      .wdata(sres_ff),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // Sequencer next-state logic.
   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      rate_in = rate_ff;
      order_in = order_ff;
      change_in = change_ff;
      flag_in = flag_ff;
      count_in = count_ff;
      sim_time_in = sim_time_ff;
      halted_in = halted_ff;
      r_in = r_ff;
      pick_in = pick_ff;
      s_in = s_ff;
      h_in = h_ff;
      bin_in = bin_ff;
      sa_in = sa_ff;
      sb_in = sb_ff;
      sres_in = sres_ff;
      p0_in = p0_ff;
      p0w_in = p0w_ff;
      n_in = n_ff;
      f2_in = f2_ff;
      a0_in = a0_ff;
      sum_in = sum_ff;
      target_in = target_ff;
      l_in = l_ff;
      dq_in = dq_ff;
      rem_in = rem_ff;
      m_in = m_ff;
      frac_in = frac_ff;
      rt_in = rt_ff;
      rp_in = rp_ff;
      e_in = e_ff;
      it_in = it_ff;
      mul_a = 32'd0;
      mul_b = 32'd0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in = status_ff;
      react_in = react_ff;
      time_out_in = time_out_ff;
      dt_out_in = dt_out_ff;
      a0_out_in = a0_out_ff;
      cnt_out_in = cnt_out_ff;
      ord = 2'd0;
      sm_tot = {32'd0, p0_ff} + {mul_p_ff, 32'd0};
      sm_ovf = ((sa_ff[63:32] != 32'd0) && (sb_ff[63:32] != 32'd0)) ||
               (sm_tot[95:64] != 32'd0);
      q3 = {1'b0, mul_p_ff[63:33]};
      three_q = {q3[30:0], 1'b0} + q3;
      rm = n_ff - three_q;
      f0 = n_ff;
      f1 = n_ff - 32'd1;
      f2 = n_ff - 32'd2;
      sq = mul_p_ff[63:31];
      ehi = 6'd32 - {1'b0, e_ff};
      nrem = {rem_ff, dq_ff[63]};
      ge = nrem >= {1'b0, a0_ff};
      nsum = sat_add(sum_ff, ram_rdata);
      upd = 64'd0;
      nib = 4'd0;
      dec = 32'd0;
      inc = 33'd0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in = gdm_pkg::ST_DONE;
               react_in = gdm_pkg::NO_REACTION;
               dt_out_in = 64'd0;
               a0_out_in = 64'd0;
               cnt_out_in = 32'd0;
               time_out_in = sim_time_ff;
               rt_in = (req_rtime == 32'd0) ? 32'd1 : req_rtime;
               rp_in = req_rpick;
               case (req_op)
                  gdm_pkg::OP_WRITE_REACTION: begin
                     if (32'(req_index) < NUM_REACTIONS) begin
                        rate_in[RW'(req_index)] = req_rate;
                        order_in[RW'(req_index)] = req_orders;
                        change_in[RW'(req_index)] = req_changes;
                        flag_in[RW'(req_index)] = req_stoch;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  gdm_pkg::OP_WRITE_COUNT: begin
                     if (32'(req_index) < NUM_SPECIES) begin
                        count_in[SW'(req_index)] = req_count;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  gdm_pkg::OP_CLEAR: begin
                     sim_time_in = 64'd0;
                     halted_in = 1'b0;
                     time_out_in = 64'd0;
                     rsp_valid_in = 1'b1;
                  end
                  gdm_pkg::OP_READ_COUNT: begin
                     if (32'(req_index) < NUM_SPECIES) begin
                        cnt_out_in = cnt_rd;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  gdm_pkg::OP_SIMULATE: begin
                     r_in = '0;
                     a0_in = 64'd0;
                     state_in = S_P_START;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         // Propensity of reaction r: its rate times the product of binomials over species.
         S_P_START: begin
            h_in = 64'd1;
            s_in = 4'd0;
            state_in = S_P_SPEC;
         end
         S_P_SPEC: begin
            if (s_ff == 4'(SL)) begin
               state_in = S_P_RATE;
            end else begin
               ord = order_ff[r_ff][2*s_ff +: 2];
               n_in = cnt_rd;
               case (ord)
                  2'd0: s_in = s_ff + 4'd1;
                  2'd1: begin
                     bin_in = {32'd0, cnt_rd};
                     state_in = S_P_HMUL;
                  end
                  2'd2: begin
                     if (cnt_rd < 32'd2) begin
                        bin_in = 64'd0;
                        state_in = S_P_HMUL;
                     end else begin
                        sa_in = {32'd0, cnt_rd};
                        sb_in = {32'd0, cnt_rd - 32'd1};
                        ret_in = S_P_B2;
                        state_in = S_SM0;
                     end
                  end
                  default: begin
                     if (cnt_rd < 32'd3) begin
                        bin_in = 64'd0;
                        state_in = S_P_HMUL;
                     end else begin
                        mul_a = cnt_rd;
                        mul_b = gdm_pkg::RECIP3;
                        state_in = S_P_D3;
                     end
                  end
               endcase
            end
         end
         S_P_B2: begin
            bin_in = {1'b0, sres_ff[63:1]};
            state_in = S_P_HMUL;
         end
         S_P_D3: begin
            // The factor divisible by three is replaced by the quotient, then
            // the first even factor is halved.
            case (rm[1:0])
               2'd0: f0 = q3;
               2'd1: f1 = q3;
               default: f2 = q3;
            endcase
            if (!f0[0]) begin
               f0 = {1'b0, f0[31:1]};
            end else if (!f1[0]) begin
               f1 = {1'b0, f1[31:1]};
            end else begin
               f2 = {1'b0, f2[31:1]};
            end
            sa_in = {32'd0, f0};
            sb_in = {32'd0, f1};
            f2_in = f2;
            ret_in = S_P_B3A;
            state_in = S_SM0;
         end
         S_P_B3A: begin
            sa_in = sres_ff;
            sb_in = {32'd0, f2_ff};
            ret_in = S_P_B3B;
            state_in = S_SM0;
         end
         S_P_B3B: begin
            bin_in = sres_ff;
            state_in = S_P_HMUL;
         end
         S_P_HMUL: begin
            sa_in = h_ff;
            sb_in = bin_ff;
            ret_in = S_P_HDONE;
            state_in = S_SM0;
         end
         S_P_HDONE: begin
            h_in = sres_ff;
            s_in = s_ff + 4'd1;
            state_in = S_P_SPEC;
         end
         S_P_RATE: begin
            sa_in = {32'd0, rate_ff[r_ff]};
            sb_in = h_ff;
            ret_in = S_P_STORE;
            state_in = S_SM0;
         end
         S_P_STORE: begin
            if (flag_ff[r_ff]) begin
               a0_in = sat_add(a0_ff, sres_ff);
            end
            if (r_ff == RW'(NUM_REACTIONS - 1)) begin
               state_in = S_HALT_CHK;
            end else begin
               r_in = r_ff + 1'b1;
               state_in = S_P_START;
            end
         end

         S_HALT_CHK: begin
            a0_out_in = a0_ff;
            if ((a0_ff == 64'd0) || halted_ff) begin
               halted_in = 1'b1;
               status_in = gdm_pkg::ST_HALTED;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               m_in = rt_ff;
               e_in = 5'd31;
               state_in = S_LN_NORM;
            end
         end

         // Normalize r1 to a Q1.31 mantissa, one bit a cycle.
         S_LN_NORM: begin
            if (m_ff[31]) begin
               it_in = 6'd0;
               frac_in = 32'd0;
               state_in = S_LN_SQ;
            end else begin
               m_in = {m_ff[30:0], 1'b0};
               e_in = e_ff - 5'd1;
            end
         end
         // Fraction bits of log2 by repeated squaring.
         S_LN_SQ: begin
            mul_a = m_ff;
            mul_b = m_ff;
            state_in = S_LN_SQU;
         end
         S_LN_SQU: begin
            frac_in = {frac_ff[30:0], sq[32]};
            m_in = sq[32] ? sq[32:1] : sq[31:0];
            it_in = it_ff + 6'd1;
            state_in = (it_ff == 6'd31) ? S_LN_FIN : S_LN_SQ;
         end
         S_LN_FIN: begin
            l_in = {26'd0, ehi, 32'd0} - {32'd0, frac_ff};
            state_in = S_LN_M0;
         end
         // Scale -log2 by ln 2.
         S_LN_M0: begin
            mul_a = l_ff[63:32];
            mul_b = gdm_pkg::LN2_Q32;
            state_in = S_LN_M1;
         end
         S_LN_M1: begin
            p0w_in = mul_p_ff;
            mul_a = l_ff[31:0];
            mul_b = gdm_pkg::LN2_Q32;
            state_in = S_LN_M2;
         end
         S_LN_M2: begin
            l_in = p0w_ff + {32'd0, mul_p_ff[63:32]};
            state_in = S_DIV_INIT;
         end

         // Restoring division of the scaled log by a0, one bit a cycle.
         S_DIV_INIT: begin
            dq_in = {l_ff[47:0], 16'd0};
            rem_in = 64'd0;
            it_in = 6'd0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = ge ? 64'(nrem - {1'b0, a0_ff}) : nrem[63:0];
            dq_in = {dq_ff[62:0], ge};
            it_in = it_ff + 6'd1;
            if (it_ff == 6'd63) begin
               state_in = S_TG0;
            end
         end

         // Selection target r2 * a0.
         S_TG0: begin
            mul_a = rp_ff;
            mul_b = a0_ff[63:32];
            state_in = S_TG1;
         end
         S_TG1: begin
            p0w_in = mul_p_ff;
            mul_a = rp_ff;
            mul_b = a0_ff[31:0];
            state_in = S_TG2;
         end
         S_TG2: begin
            target_in = p0w_ff + {32'd0, mul_p_ff[63:32]};
            r_in = '0;
            pick_in = '0;
            sum_in = 64'd0;
            s_in = 4'd0;
            state_in = ((p0w_ff + {32'd0, mul_p_ff[63:32]}) == 64'd0) ? S_APPLY :
                       S_SEL_ADDR;
         end

         // Walk the stored propensities for the first flagged reaction
         // whose running sum reaches the target.
         S_SEL_ADDR: begin
            state_in = S_SEL_DATA;
         end
         S_SEL_DATA: begin
            if (flag_ff[r_ff]) begin
               pick_in = r_ff;
               sum_in = nsum;
            end
            if ((flag_ff[r_ff] && (nsum >= target_ff)) ||
                (r_ff == RW'(NUM_REACTIONS - 1))) begin
               s_in = 4'd0;
               state_in = S_APPLY;
            end else begin
               r_in = r_ff + 1'b1;
               state_in = S_SEL_ADDR;
            end
         end

         // Apply the change vector, one species a cycle, saturating.
         S_APPLY: begin
            if (s_ff == 4'(SL)) begin
               sim_time_in = sat_add(sim_time_ff, dq_ff);
               time_out_in = sat_add(sim_time_ff, dq_ff);
               dt_out_in = dq_ff;
               status_in = gdm_pkg::ST_FIRED;
               react_in = 5'(pick_ff);
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               nib = change_ff[pick_ff][4*s_ff +: 4];
               if (nib[3]) begin
                  dec = 32'd16 - {28'd0, nib};
                  count_in[SW'(s_ff)] = (cnt_rd < dec) ? 32'd0 : cnt_rd - dec;
               end else begin
                  inc = {1'b0, cnt_rd} + {29'd0, nib};
                  count_in[SW'(s_ff)] = inc[32] ? 32'hFFFF_FFFF : inc[31:0];
               end
               s_in = s_ff + 4'd1;
            end
         end

         // Saturating 64x64 multiply from 32x32 partial products.
         S_SM0: begin
            mul_a = sa_ff[31:0];
            mul_b = sb_ff[31:0];
            state_in = S_SM1;
         end
         S_SM1: begin
            p0w_in = mul_p_ff;
            if (sa_ff[63:32] != 32'd0) begin
               mul_a = sa_ff[63:32];
               mul_b = sb_ff[31:0];
            end else begin
               mul_a = sa_ff[31:0];
               mul_b = sb_ff[63:32];
            end
            state_in = S_SM2;
         end
         S_SM2: begin
            upd = p0w_ff;
            sm_tot = {32'd0, upd} + {mul_p_ff, 32'd0};
            sm_ovf = ((sa_ff[63:32] != 32'd0) && (sb_ff[63:32] != 32'd0)) ||
                     (sm_tot[95:64] != 32'd0);
            sres_in = sm_ovf ? gdm_pkg::U64_MAX : sm_tot[63:0];
            state_in = ret_ff;
         end

         default: state_in = S_IDLE;
      endcase
      p0_in = p0w_in[31:0];
   end

   // State, tables and registered outputs.
   always_ff @(posedge clock) begin
      mul_p_ff <= mul_a * mul_b;
      ret_ff <= ret_in;
      r_ff <= r_in;
      pick_ff <= pick_in;
      s_ff <= s_in;
      h_ff <= h_in;
      bin_ff <= bin_in;
      sa_ff <= sa_in;
      sb_ff <= sb_in;
      sres_ff <= sres_in;
      p0_ff <= p0_in;
      p0w_ff <= p0w_in;
      n_ff <= n_in;
      f2_ff <= f2_in;
      a0_ff <= a0_in;
      sum_ff <= sum_in;
      target_ff <= target_in;
      l_ff <= l_in;
      dq_ff <= dq_in;
      rem_ff <= rem_in;
      m_ff <= m_in;
      frac_ff <= frac_in;
      rt_ff <= rt_in;
      rp_ff <= rp_in;
      e_ff <= e_in;
      it_ff <= it_in;
      status_ff <= status_in;
      react_ff <= react_in;
      time_out_ff <= time_out_in;
      dt_out_ff <= dt_out_in;
      a0_out_ff <= a0_out_in;
      cnt_out_ff <= cnt_out_in;
      if (reset) begin
         state_ff <= S_IDLE;
         sim_time_ff <= 64'd0;
         halted_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_REACTIONS; i++) begin
            rate_ff[i] <= 32'd0;
            order_ff[i] <= 16'd0;
            change_ff[i] <= 32'd0;
            flag_ff[i] <= 1'b0;
         end
         for (int i = 0; i < NUM_SPECIES; i++) begin
            count_ff[i] <= 32'd0;
         end
      end else begin
         state_ff <= state_in;
         sim_time_ff <= sim_time_in;
         halted_ff <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
         rate_ff <= rate_in;
         order_ff <= order_in;
         change_ff <= change_in;
         flag_ff <= flag_in;
         count_ff <= count_in;
      end
   end

   // Response word.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = status_ff;
   assign rsp_tdata = {3'd0, cnt_out_ff, a0_out_ff, dt_out_ff, time_out_ff, react_ff};

endmodule

`default_nettype wire

@@ hw/rtl/gdm_ram.sv @@
`default_nettype none

module gdm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                       wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

@@ hw/rtl/gdm_checker.sv @@
`default_nettype none

module gdm_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [231:0] rsp_tdata,
   input wire logic [1:0]   rsp_tuser
);

   // A response word waits until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response word dropped before it was taken");

   // A halted event names no reaction.
   a_halt_none: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == gdm_pkg::ST_HALTED) |->
      (rsp_tdata[4:0] == gdm_pkg::NO_REACTION))
      else $error("halted response names a reaction");

   // Only a fired event advances time.
   a_step_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != gdm_pkg::ST_FIRED) |-> (rsp_tdata[132:69] == 64'd0))
      else $error("time step without a fired reaction");

   // A fired event has a nonzero total propensity.
   a_fired_total: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == gdm_pkg::ST_FIRED) |-> (rsp_tdata[196:133] != 64'd0))
      else $error("reaction fired with zero total propensity");

endmodule

bind gillespie_direct_method_step gdm_checker u_gdm_checker (
   .clock(clock),
   .reset(reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);

`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none

module testbench;

   // Operation codes the block does not decode; it answers them like a no-op.
   localparam logic [2:0] OP_UNKNOWN_LO = 3'd5;
   localparam logic [2:0] OP_UNKNOWN_HI = 3'd7;
   localparam int RANDOM_ITEMS = 1100;
   localparam int DRAIN_CYCLES = 50;

   typedef struct packed {
      logic [2:0]  op;
      logic [3:0]  idx;
      logic [31:0] rate;
      logic [15:0] orders;
      logic [31:0] changes;
      logic        stoch;
      logic [31:0] count;
      logic [31:0] rand_time;
      logic [31:0] rand_pick;
   } event_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  reaction;
      logic [63:0] sim_time;
      logic [63:0] time_step;
      logic [63:0] a0;
      logic [31:0] count;
   } event_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [183:0] req_tdata = '0;
   logic [2:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [231:0] rsp_tdata;
   logic [1:0] rsp_tuser;

   gillespie_direct_method_step uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Shadow copy of the engine state.
   logic [31:0] rate_tbl [16];
   logic [15:0] order_tbl [16];
   logic [31:0] change_tbl [16];
   logic        flag_tbl [16];
   logic [31:0] species [8];
   logic [63:0] model_time;
   logic        model_halted;

   event_rsp_type pending_rsp [$];
   int errors = 0;
   int sent = 0;
   int rx_hold = 0;
   bit tx_quiet = 1'b0;

   function automatic logic [63:0] sat_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = a * b;
      return (p[127:64] != 0) ? gdm_pkg::U64_MAX : p[63:0];
   endfunction

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + b;
      return s[64] ? gdm_pkg::U64_MAX : s[63:0];
   endfunction

   // Number of ways to choose ord molecules out of n, saturating.
   function automatic logic [63:0] choose(input logic [63:0] n, input logic [1:0] ord);
      logic [63:0] f [3];
      bit done;
      if (ord == 0) return 64'd1;
      if (ord == 1) return n;
      if (n < ord) return 64'd0;
      if (ord == 2) return (n * (n - 1)) / 2;
      f[0] = n;
      f[1] = n - 1;
      f[2] = n - 2;
      done = 0;
      for (int i = 0; i < 3; i++) begin
         if (!done && f[i] % 3 == 0) begin
            f[i] = f[i] / 3;
            done = 1;
         end
      end
      done = 0;
      for (int i = 0; i < 3; i++) begin
         if (!done && !f[i][0]) begin
            f[i] = f[i] / 2;
            done = 1;
         end
      end
      return sat_mul(sat_mul(f[0], f[1]), f[2]);
   endfunction

   function automatic logic [63:0] reaction_propensity(input int r);
      logic [63:0] h;
      h = 64'd1;
      for (int s = 0; s < 8; s++)
         h = sat_mul(h, choose({32'd0, species[s]}, order_tbl[r][2*s +: 2]));
      return sat_mul({32'd0, rate_tbl[r]}, h);
   endfunction

   // -ln(x / 2^32) in Q32.32 via a squaring log2 and a scale by ln 2.
   function automatic logic [63:0] neg_log(input logic [31:0] x);
      int e;
      logic [63:0] m, frac, nl2, lo;
      e = 31;
      while (x[e] == 1'b0) e--;
      m = {32'd0, x} << (31 - e);
      frac = 0;
      for (int i = 0; i < 32; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            frac[0] = 1'b1;
            m = m >> 1;
         end
      end
      nl2 = ({32'd0, 32'(32 - e)} << 32) - frac;
      lo = ({32'd0, nl2[31:0]} * {32'd0, gdm_pkg::LN2_Q32}) >> 32;
      return {32'd0, nl2[63:32]} * {32'd0, gdm_pkg::LN2_Q32} + lo;
   endfunction

   // Advance the shadow state by one request and return the answer it owes.
   function automatic event_rsp_type predict_event(input event_req_type q);
      event_rsp_type a;
      logic [63:0] prop [16];
      logic [63:0] target, sum, dt;
      logic [31:0] r1, c;
      logic [3:0] nib;
      int pick;
      bit found;
      a = '0;
      a.status = gdm_pkg::ST_DONE;
      a.reaction = gdm_pkg::NO_REACTION;
      case (q.op)
         gdm_pkg::OP_WRITE_REACTION: begin
            rate_tbl[q.idx] = q.rate;
            order_tbl[q.idx] = q.orders;
            change_tbl[q.idx] = q.changes;
            flag_tbl[q.idx] = q.stoch;
         end
         gdm_pkg::OP_WRITE_COUNT: begin
            if (q.idx < 8) species[q.idx[2:0]] = q.count;
         end
         gdm_pkg::OP_CLEAR: begin
            model_time = 0;
            model_halted = 1'b0;
         end
         gdm_pkg::OP_READ_COUNT: begin
            if (q.idx < 8) a.count = species[q.idx[2:0]];
         end
         gdm_pkg::OP_SIMULATE: begin
            for (int r = 0; r < 16; r++) begin
               prop[r] = reaction_propensity(r);
               if (flag_tbl[r]) a.a0 = sat_add(a.a0, prop[r]);
            end
            if (a.a0 == 0) model_halted = 1'b1;
            if (model_halted) begin
               a.status = gdm_pkg::ST_HALTED;
            end else begin
               r1 = (q.rand_time == 0) ? 32'd1 : q.rand_time;
               dt = (neg_log(r1) << 16) / a.a0;
               target = {32'd0, q.rand_pick} * {32'd0, a.a0[63:32]}
                  + (({32'd0, q.rand_pick} * {32'd0, a.a0[31:0]}) >> 32);
               pick = 0;
               sum = 0;
               found = 0;
               if (target != 0) begin
                  for (int r = 0; r < 16; r++) begin
                     if (flag_tbl[r] && !found) begin
                        pick = r;
                        sum = sat_add(sum, prop[r]);
                        if (sum >= target) found = 1;
                     end
                  end
               end
               model_time = sat_add(model_time, dt);
               // Apply the signed nibble changes with clamping at both ends.
               for (int s = 0; s < 8; s++) begin
                  nib = change_tbl[pick][4*s +: 4];
                  c = species[s];
                  if (nib[3])
                     species[s] = (c < 32'(16 - nib)) ? 32'd0 : c - 32'(16 - nib);
                  else
                     species[s] = (c > 32'hFFFF_FFFF - nib) ? 32'hFFFF_FFFF : c + nib;
               end
               a.status = gdm_pkg::ST_FIRED;
               a.reaction = 5'(pick);
               a.time_step = dt;
            end
         end
         default: ;
      endcase
      a.sim_time = model_time;
      return a;
   endfunction

   // Offer one request word, wait for acceptance and log what it should answer.
   task automatic send_event(input event_req_type q);
      int gap;
      if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
      gap = tx_quiet ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= q.op;
      req_tdata <= {3'd0, q.rand_pick, q.rand_time, q.count, q.stoch, q.changes,
                    q.orders, q.rate, q.idx};
      do @(posedge clock); while (!req_tready);
      pending_rsp.push_back(predict_event(q));
      sent++;
   endtask

   function automatic event_req_type blank_event(input logic [2:0] op);
      event_req_type q;
      q = '0;
      q.op = op;
      q.rand_time = 32'h8000_0000;
      q.rand_pick = 32'h8000_0000;
      return q;
   endfunction

   function automatic event_req_type any_event();
      event_req_type q;
      q.op = 3'($urandom_range(0, 7));
      q.idx = 4'($urandom);
      q.rate = $urandom;
      q.orders = 16'($urandom);
      q.changes = $urandom;
      q.stoch = 1'($urandom);
      q.count = $urandom;
      q.rand_time = $urandom;
      q.rand_pick = $urandom;
      return q;
   endfunction

   task automatic put_reaction(input int r, input logic [31:0] rate, input logic [15:0] ord,
                               input logic [31:0] chg, input logic fl);
      event_req_type q;
      q = blank_event(gdm_pkg::OP_WRITE_REACTION);
      q.idx = 4'(r);
      q.rate = rate;
      q.orders = ord;
      q.changes = chg;
      q.stoch = fl;
      send_event(q);
   endtask

   task automatic put_count(input int s, input logic [31:0] n);
      event_req_type q;
      q = blank_event(gdm_pkg::OP_WRITE_COUNT);
      q.idx = 4'(s);
      q.count = n;
      send_event(q);
   endtask

   task automatic run_sim(input logic [31:0] rt, input logic [31:0] rp);
      event_req_type q;
      q = blank_event(gdm_pkg::OP_SIMULATE);
      q.rand_time = rt;
      q.rand_pick = rp;
      send_event(q);
   endtask

   // Field extremes, every operation and the corner cases of selection and halt.
   task automatic test_directed();
      event_req_type q;
      run_sim(32'd1, 32'd0);                         // empty table halts
      run_sim(32'hFFFF_FFFF, 32'hFFFF_FFFF);         // still halted
      q = blank_event(gdm_pkg::OP_CLEAR);
      send_event(q);
      put_reaction(0, 32'h0001_0000, 16'h0000, 32'h0000_0001, 1'b0);
      put_reaction(1, 32'h0001_0000, 16'h0000, 32'h0000_000F, 1'b1);
      run_sim(32'd0, 32'd0);                         // zero target picks unflagged 0
      run_sim(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      put_count(7, 32'hFFFF_FFFF);
      put_count(8, 32'd5);                           // out of range, dropped
      put_reaction(15, 32'hFFFF_FFFF, 16'hFFFF, 32'h8888_8888, 1'b1);
      put_reaction(14, 32'h0000_0001, 16'hC000, 32'h7777_7777, 1'b1);
      put_count(0, 32'd3);
      put_count(1, 32'd2);
      run_sim(32'h0000_0001, 32'h4000_0000);
      run_sim(32'h8000_0000, 32'hFFFF_FFFF);
      q = blank_event(gdm_pkg::OP_READ_COUNT);
      q.idx = 4'd7;
      send_event(q);
      q.idx = 4'd15;
      send_event(q);
      for (logic [2:0] op = OP_UNKNOWN_LO; op <= OP_UNKNOWN_HI && op != 0; op++) begin
         q = any_event();
         q.op = op;
         send_event(q);
      end
      q = blank_event(gdm_pkg::OP_CLEAR);
      send_event(q);
   endtask

   // Build small reaction systems and run them for a while, mixed with noise.
   task automatic test_random();
      event_req_type q;
      int n;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 2) == 0) send_event(blank_event(gdm_pkg::OP_CLEAR));
            n = $urandom_range(1, 5);
            repeat (n) begin
               put_reaction($urandom_range(0, 15),
                            ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32'h4_0000),
                            16'($urandom) & 16'($urandom),
                            $urandom, $urandom_range(0, 5) != 0);
            end
            n = $urandom_range(0, 4);
            repeat (n) begin
               put_count($urandom_range(0, 9),
                         ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 30));
            end
            n = $urandom_range(2, 10);
            repeat (n) begin
               if ($urandom_range(0, 5) == 0) begin
                  q = blank_event(gdm_pkg::OP_READ_COUNT);
                  q.idx = 4'($urandom_range(0, 9));
                  send_event(q);
               end else begin
                  run_sim($urandom, ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom);
               end
            end
         end else begin
            send_event(any_event());
         end
      end
   endtask

   // Hold the response side off so the block stalls its request side.
   task automatic test_backpressure();
      rx_hold = 300;
      put_reaction(2, 32'h0002_0000, 16'h0001, 32'h0000_0011, 1'b1);
      put_count(0, 32'd40);
      repeat (4) run_sim($urandom, $urandom);
      repeat (4) send_event(blank_event(gdm_pkg::OP_READ_COUNT));
   endtask

   // Response side: random stalls, then compare every word with the oldest prediction.
   int rx_stall = 0;
   bit rx_quiet = 1'b0;
   always @(posedge clock) begin
      event_rsp_type exp_rsp, got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[4:0], rsp_tdata[68:5], rsp_tdata[132:69],
                   rsp_tdata[196:133], rsp_tdata[228:197]};
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected word, actual %h", $time, got);
               errors++;
            end else begin
               exp_rsp = pending_rsp.pop_front();
               if (got.status !== exp_rsp.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           exp_rsp.status, got.status);
                  errors++;
               end
               if (got.reaction !== exp_rsp.reaction) begin
                  $display("%0t: reaction expected %0d actual %0d", $time,
                           exp_rsp.reaction, got.reaction);
                  errors++;
               end
               if (got.sim_time !== exp_rsp.sim_time) begin
                  $display("%0t: sim_time expected %h actual %h", $time,
                           exp_rsp.sim_time, got.sim_time);
                  errors++;
               end
               if (got.time_step !== exp_rsp.time_step) begin
                  $display("%0t: time_step expected %h actual %h", $time,
                           exp_rsp.time_step, got.time_step);
                  errors++;
               end
               if (got.a0 !== exp_rsp.a0) begin
                  $display("%0t: total_propensity expected %h actual %h", $time,
                           exp_rsp.a0, got.a0);
                  errors++;
               end
               if (got.count !== exp_rsp.count) begin
                  $display("%0t: count_out expected %h actual %h", $time,
                           exp_rsp.count, got.count);
                  errors++;
               end
            end
            if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
            rx_stall = rx_quiet ? 0 : $urandom_range(0, 13);
         end
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_tready <= 1'b0;
         end else if (rx_stall > 0) begin
            rx_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      for (int r = 0; r < 16; r++) begin
         rate_tbl[r] = 0;
         order_tbl[r] = 0;
         change_tbl[r] = 0;
         flag_tbl[r] = 0;
      end
      for (int s = 0; s < 8; s++) species[s] = 0;
      model_time = 0;
      model_halted = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #300000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
hw/rtl/gdm_pkg.sv
hw/rtl/gdm_ram.sv
hw/rtl/gillespie_direct_method_step.sv
hw/rtl/gdm_checker.sv
tb/testbench.sv
